@@ hdl/dqi_pkg.sv @@
package dqi_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int HANDLE_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_APPEND     = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_ITER_START = 3'd3,
        KIND_ITER_NEXT  = 3'd4,
        KIND_CLEAR      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_NULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

endpackage

@@ hdl/dqi_cell.sv @@
module dqi_cell
    import dqi_pkg::*;
#(
    parameter int PTR_W        = 4,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF,
    parameter int CELL_IDX     = 0
)
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [PTR_W-1:0]        wr_idx,
    input  logic [HANDLE_WIDTH-1:0] wr_data,
    input  logic [PTR_W-1:0]        rd_idx,
    input  logic [HANDLE_WIDTH-1:0] chain_in,
    output logic [HANDLE_WIDTH-1:0] chain_out
);

    localparam logic [PTR_W-1:0] MY_IDX = PTR_W'(CELL_IDX);

    logic [HANDLE_WIDTH-1:0] slot_reg;
    logic [HANDLE_WIDTH-1:0] slot_next;
    logic [HANDLE_WIDTH-1:0] pass_reg;
    logic [HANDLE_WIDTH-1:0] pass_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (wr_en && (wr_idx == MY_IDX))
        begin
            slot_next = wr_data;
        end
        // insert own handle when selected, else pass the neighbor's down
        pass_next = (rd_idx == MY_IDX) ? slot_reg : chain_in;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        pass_reg <= pass_next;
    end

    assign chain_out = pass_reg;

endmodule

@@ hdl/dqi_chain.sv @@
module dqi_chain
    import dqi_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_idx,
    input  logic [HANDLE_WIDTH-1:0]    wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_idx,
    output logic [HANDLE_WIDTH-1:0]    rd_data
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [HANDLE_WIDTH-1:0] link [DEPTH+1];

    assign link[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dqi_cell #(
            .PTR_W        (PTR_W),
            .HANDLE_WIDTH (HANDLE_WIDTH),
            .CELL_IDX     (i)
        ) u_cell (
            .clk       (clk),
            .wr_en     (wr_en),
            .wr_idx    (wr_idx),
            .wr_data   (wr_data),
            .rd_idx    (rd_idx),
            .chain_in  (link[i+1]),
            .chain_out (link[i])
        );
    end

    assign rd_data = link[0];

endmodule

@@ hdl/deque_with_iterator.sv @@
// Push, append, iterator start, clear, unused kinds, empty pop and ended iterator
// next: one item per cycle unless the output stalls; result goes to the output
// register on accept, or via ST_HOLD. Pop and iterator next that return a handle:
// ST_SCAN as the read chain walks it to cell zero, then ST_HOLD; in_stall till done.
// Reset (rst_n low, asynchronous): queue empty, head at slot zero, iterator
// ended, no result pending. Slot contents are not cleared.
module deque_with_iterator
    import dqi_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   kind,
    input  logic [HANDLE_WIDTH-1:0]      value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [HANDLE_WIDTH-1:0]      item,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    state_t                   state_reg, state_next;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [PTR_W-1:0]         iter_slot_reg, iter_slot_next;
    logic [CNT_W-1:0]         iter_left_reg, iter_left_next;
    logic [PTR_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]         scan_reg, scan_next;
    logic                     out_valid_reg, out_valid_next;

    status_t                  pend_status_reg, pend_status_next;
    logic [HANDLE_WIDTH-1:0]  pend_item_reg, pend_item_next;
    logic [CNT_W-1:0]         pend_count_reg, pend_count_next;
    status_t                  status_reg, status_next;
    logic [HANDLE_WIDTH-1:0]  item_reg, item_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic                     accept;
    logic                     out_free;
    logic                     is_read;
    status_t                  res_status;
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_idx;
    logic [HANDLE_WIDTH-1:0]  rd_data;

    logic [PTR_W-1:0]         head_dec;
    logic [PTR_W-1:0]         iter_inc;
    logic [SUM_W-1:0]         tail_sum;
    logic [SUM_W-1:0]         back_sum;
    logic [SUM_W-1:0]         tail_wrap;
    logic [SUM_W-1:0]         back_wrap;
    logic [PTR_W-1:0]         tail_idx;
    logic [PTR_W-1:0]         back_idx;
    logic                     is_null;
    logic                     is_full;

    dqi_chain #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_chain (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (value),
        .rd_idx  (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // ring arithmetic on the pointers
    always_comb
    begin
        head_dec  = (head_reg == '0) ? LAST_IDX : head_reg - PTR_W'(1);
        iter_inc  = (iter_slot_reg == LAST_IDX) ? '0 : iter_slot_reg + PTR_W'(1);
        tail_sum  = SUM_W'(head_reg) + SUM_W'(cnt_reg);
        back_sum  = tail_sum - SUM_W'(1);
        tail_wrap = (tail_sum >= DEPTH_SUM) ? tail_sum - DEPTH_SUM : tail_sum;
        back_wrap = (back_sum >= DEPTH_SUM) ? back_sum - DEPTH_SUM : back_sum;
        tail_idx  = tail_wrap[PTR_W-1:0];
        back_idx  = back_wrap[PTR_W-1:0];
        is_null   = (value == '0);
        is_full   = (cnt_reg == DEPTH_CNT);
    end

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        cnt_next         = cnt_reg;
        iter_slot_next   = iter_slot_reg;
        iter_left_next   = iter_left_reg;
        rd_idx_next      = rd_idx_reg;
        scan_next        = scan_reg;
        pend_status_next = pend_status_reg;
        pend_item_next   = pend_item_reg;
        pend_count_next  = pend_count_reg;
        status_next      = status_reg;
        item_next        = item_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        wr_en            = 1'b0;
        wr_idx           = head_dec;
        is_read          = 1'b0;
        res_status       = STAT_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind_t'(kind))
                        KIND_PUSH_FRONT:
                        begin
                            if (is_null)
                                res_status = STAT_NULL;
                            else if (is_full)
                                res_status = STAT_FULL;
                            else
                            begin
                                head_next = head_dec;
                                wr_en     = 1'b1;
                                wr_idx    = head_dec;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        KIND_APPEND:
                        begin
                            if (is_null)
                                res_status = STAT_NULL;
                            else if (is_full)
                                res_status = STAT_FULL;
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_idx   = tail_idx;
                                cnt_next = cnt_reg + CNT_W'(1);
                                if (iter_left_reg != '0)
                                    iter_left_next = iter_left_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            if (cnt_reg == '0)
                                res_status = STAT_EMPTY;
                            else
                            begin
                                is_read     = 1'b1;
                                rd_idx_next = back_idx;
                                cnt_next    = cnt_reg - CNT_W'(1);
                                if (iter_left_reg != '0)
                                    iter_left_next = iter_left_reg - CNT_W'(1);
                            end
                        end
                        KIND_ITER_START:
                        begin
                            iter_slot_next = head_reg;
                            iter_left_next = cnt_reg;
                            if (cnt_reg == '0)
                                res_status = STAT_EMPTY;
                        end
                        KIND_ITER_NEXT:
                        begin
                            if (iter_left_reg == '0)
                                res_status = STAT_EMPTY;
                            else
                            begin
                                is_read        = 1'b1;
                                rd_idx_next    = iter_slot_reg;
                                iter_slot_next = iter_inc;
                                iter_left_next = iter_left_reg - CNT_W'(1);
                            end
                        end
                        KIND_CLEAR:
                        begin
                            head_next      = '0;
                            cnt_next       = '0;
                            iter_slot_next = '0;
                            iter_left_next = '0;
                        end
                        default:
                        begin
                            res_status = STAT_OK;
                        end
                    endcase

                    if (is_read)
                    begin
                        state_next       = ST_SCAN;
                        scan_next        = '0;
                        pend_status_next = STAT_OK;
                        pend_count_next  = cnt_next;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = res_status;
                        item_next      = '0;
                        count_next     = cnt_next;
                    end
                    else
                    begin
                        state_next       = ST_HOLD;
                        pend_status_next = res_status;
                        pend_item_next   = '0;
                        pend_count_next  = cnt_next;
                    end
                end
            end
            ST_SCAN:
            begin
                // advance until the selected handle has reached cell zero
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg == DEPTH_CNT)
                begin
                    pend_item_next = rd_data;
                    state_next     = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_status_reg;
                    item_next      = pend_item_reg;
                    count_next     = pend_count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            iter_slot_reg <= '0;
            iter_left_reg <= '0;
            rd_idx_reg    <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            iter_slot_reg <= iter_slot_next;
            iter_left_reg <= iter_left_next;
            rd_idx_reg    <= rd_idx_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_item_reg   <= pend_item_next;
        pend_count_reg  <= pend_count_next;
        status_reg      <= status_next;
        item_reg        <= item_next;
        count_reg       <= count_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign item      = item_reg;
    assign count     = count_reg;

endmodule
